// File: hw/rtl/shbi_pkg.sv
// ----------------------------------------------------------------------------
// shbi_pkg
// Shared widths and constants for the string hash bucket index block.
// ----------------------------------------------------------------------------
`default_nettype none

package shbi_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned POS_W    = 16;
  localparam int unsigned ACC_W    = 32;
  localparam int unsigned BUCKET_W = 25;
  localparam int unsigned INDEX_W  = 24;

  // Byte position saturates here until the identifier ends.
  localparam int unsigned MAX_LEN = 65535;

  localparam logic [BUCKET_W-1:0] BUCKET_RESET = 25'd1536;
  localparam logic [BUCKET_W-1:0] BUCKET_MAX   = 25'h100_0000;

  // Default depth of the queue between the hash and the reduction unit.
  localparam int unsigned FIFO_DEPTH = 2;

  // One quotient bit per step of the restoring reduction.
  localparam int unsigned DIV_STEPS = ACC_W;

endpackage

`default_nettype wire

// File: hw/rtl/shbi_front.sv
// ----------------------------------------------------------------------------
// shbi_front
// Byte intake and 32-bit hash accumulator; pushes the final word per
// identifier toward the reduction unit.
// ----------------------------------------------------------------------------
`default_nettype none

module shbi_front (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  wire  [shbi_pkg::BYTE_W-1:0]    data_byte_i,
  input  wire  [shbi_pkg::LEN_W-1:0]     total_len_i,
  input  wire                            last_byte_i,
  output logic                           push_valid_o,
  input  wire                            push_ready_i,
  output logic [shbi_pkg::ACC_W-1:0]     push_data_o
);
  import shbi_pkg::*;

  // Sign-extend a byte to the accumulator width.
  function automatic logic [ACC_W-1:0] sext8(input logic [BYTE_W-1:0] v);
    sext8 = {{(ACC_W-BYTE_W){v[BYTE_W-1]}}, v};
  endfunction

  // Multiple of three via base-4 digit sum (4 = 1 mod 3).
  function automatic logic is_mult3(input logic [BYTE_W-1:0] m);
    logic [3:0] s1;
    logic [2:0] s2;
    s1 = 4'(m[1:0]) + 4'(m[3:2]) + 4'(m[5:4]) + 4'(m[7:6]);
    s2 = 3'(s1[1:0]) + 3'(s1[3:2]);
    is_mult3 = (s2 == 3'd0) || (s2 == 3'd3) || (s2 == 3'd6);
  endfunction

  logic [POS_W-1:0]  pos_q, pos_d;
  logic [BYTE_W-1:0] prev_q, prev_d;
  logic [ACC_W-1:0]  acc_q, acc_d;

  logic              s1_valid_q, s1_valid_d;
  logic              s1_first_q, s1_last_q;
  logic [ACC_W-1:0]  s1_addend_q, s1_factor_q, s1_b_q;

  logic              in_fire, s1_advance;
  logic [ACC_W-1:0]  b, i, p, len, t, addend, factor, product;
  logic [BYTE_W-1:0] mag;

  // Classify the incoming byte: addend and multiplier do not depend on acc.
  always_comb begin
    b      = sext8(data_byte_i);
    i      = {{(ACC_W-POS_W){1'b0}}, pos_q};
    len    = {{(ACC_W-LEN_W){1'b0}}, total_len_i};
    p      = (pos_q == POS_W'(1)) ? b : sext8(prev_q);
    mag    = data_byte_i[BYTE_W-1] ? (~data_byte_i + BYTE_W'(1)) : data_byte_i;
    t      = is_mult3(mag) ? (b ^ ~i) : (b << i[4:0]);
    addend = b + ~t;
    factor = (b ^ i) + (len | (i + len - p));
  end

  assign s1_advance = s1_valid_q && (!s1_last_q || push_ready_i);
  assign in_ready_o = !s1_valid_q || s1_advance;
  assign in_fire    = in_valid_i && in_ready_o;

  assign product      = (acc_q + s1_addend_q) * s1_factor_q;
  assign push_valid_o = s1_valid_q && s1_last_q;
  assign push_data_o  = s1_first_q ? s1_b_q : product;

  always_comb begin
    pos_d      = pos_q;
    prev_d     = prev_q;
    acc_d      = acc_q;
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      prev_d     = data_byte_i;
      s1_valid_d = 1'b1;
      if (last_byte_i) begin
        pos_d = '0;
      end else if (pos_q < POS_W'(MAX_LEN)) begin
        pos_d = pos_q + POS_W'(1);
      end
    end else if (s1_advance) begin
      s1_valid_d = 1'b0;
    end
    // Accumulate; the first byte leaves acc at zero.
    if (s1_advance) begin
      if (s1_last_q) begin
        acc_d = '0;
      end else if (!s1_first_q) begin
        acc_d = product;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      prev_q     <= '0;
      acc_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      prev_q     <= prev_d;
      acc_q      <= acc_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_first_q  <= (pos_q == '0);
      s1_last_q   <= last_byte_i;
      s1_addend_q <= addend;
      s1_factor_q <= factor;
      s1_b_q      <= b;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/shbi_fifo.sv
// ----------------------------------------------------------------------------
// shbi_fifo
// Small queue of final hash words between the accumulator and the reducer.
// ----------------------------------------------------------------------------
`default_nettype none

module shbi_fifo #(
  parameter int unsigned Depth = shbi_pkg::FIFO_DEPTH
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         push_valid_i,
  output logic                        push_ready_o,
  input  wire  [shbi_pkg::ACC_W-1:0]  push_data_i,
  output logic                        pop_valid_o,
  input  wire                         pop_ready_i,
  output logic [shbi_pkg::ACC_W-1:0]  pop_data_o
);
  import shbi_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [ACC_W-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/shbi_back.sv
// ----------------------------------------------------------------------------
// shbi_back
// Restoring remainder unit: reduces a hash word modulo the bucket count,
// one bit per cycle, and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module shbi_back (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire  [shbi_pkg::BUCKET_W-1:0]  bucket_count_i,
  input  wire                            pop_valid_i,
  output logic                           pop_ready_o,
  input  wire  [shbi_pkg::ACC_W-1:0]     pop_data_i,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output logic [shbi_pkg::INDEX_W-1:0]   out_data_o
);
  import shbi_pkg::*;

  localparam int unsigned StepW = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StDiv  = 3'b010,
    StDone = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [StepW-1:0]   step_q, step_d;
  logic [ACC_W-1:0]   dvd_q, dvd_d;
  logic [INDEX_W-1:0] rem_q, rem_d;
  logic               out_valid_q, out_valid_d;
  logic [INDEX_W-1:0] out_data_q, out_data_d;

  logic [BUCKET_W-1:0] n;
  logic [INDEX_W:0]    shifted;
  logic                slot_free;

  // Clamp the divisor to the largest supported bucket count.
  assign n         = (bucket_count_i > BUCKET_MAX) ? BUCKET_MAX : bucket_count_i;
  assign shifted   = {rem_q, dvd_q[ACC_W-1]};
  assign slot_free = !out_valid_q || out_ready_i;

  assign pop_ready_o = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    unique case (state_q)
      StIdle: begin
        if (pop_valid_i) begin
          dvd_d   = pop_data_i;
          rem_d   = '0;
          step_d  = '0;
          state_d = StDiv;
        end
      end
      StDiv: begin
        rem_d  = (shifted >= n) ? INDEX_W'(shifted - n) : INDEX_W'(shifted);
        dvd_d  = dvd_q << 1;
        step_d = step_q + StepW'(1);
        if (step_q == StepW'(DIV_STEPS - 1)) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_data_d  = (n == '0) ? '0 : rem_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q     <= step_d;
    dvd_q      <= dvd_d;
    rem_q      <= rem_d;
    out_data_q <= out_data_d;
  end

endmodule

`default_nettype wire

// File: hw/rtl/string_hash_bucket_index.sv
// ----------------------------------------------------------------------------
// string_hash_bucket_index
// Streaming identifier hash with reduction to a bucket index.
// ----------------------------------------------------------------------------
// Usage:
//  - The slave stream carries one identifier byte per transfer, with the
//    identifier's total length on every byte; tlast marks the final byte.
//  - The master stream returns one bucket index per identifier, produced
//    for the transfer that carried tlast. Other bytes give no result.
//  - Bytes are taken at one per cycle unless a final word waits on a full
//    queue; the 32-bit multiply-accumulate of the hash runs once per cycle
//    in a two-stage front unit.
//  - The final hash word enters a short queue; the reduction unit pops it
//    and computes the remainder one bit per cycle in 32 steps, then hands
//    it to the output register; it takes no new word until then.
//  - Sustained rate: one byte per cycle while identifiers are longer than
//    the reduction time; short identifiers are limited by the reduction
//    unit once the queue is full.
//  - A stalled master holds the result in the output register; the unit
//    behind it, then the queue, then the byte intake back up in turn.
//  - Reset clears the accumulator, position, previous byte, queue and the
//    output valid, and loads the bucket count with 1536.
//  - Write the bucket count only while no identifier is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module string_hash_bucket_index #(
  parameter int unsigned FifoDepth = shbi_pkg::FIFO_DEPTH
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // Slave stream. tdata: [7:0] data_byte, [23:8] total_len. tlast: last_byte.
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire  [23:0]                    s_axis_tdata,
  input  wire                            s_axis_tlast,
  // Master stream. tdata: [23:0] bucket_index.
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  output logic [23:0]                    m_axis_tdata,
  // Bucket count register.
  input  wire                            cfg_wr_en_i,
  input  wire  [shbi_pkg::BUCKET_W-1:0]  cfg_wr_data_i
);
  import shbi_pkg::*;

  logic [BUCKET_W-1:0] bucket_count_q;

  logic             push_valid, push_ready;
  logic [ACC_W-1:0] push_data;
  logic             pop_valid, pop_ready;
  logic [ACC_W-1:0] pop_data;

  // Hold the bucket count; the reducer reads it live.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= BUCKET_RESET;
    end else if (cfg_wr_en_i) begin
      bucket_count_q <= cfg_wr_data_i;
    end
  end

  // Front: accept bytes, mix them into the accumulator.
  shbi_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .data_byte_i  (s_axis_tdata[7:0]),
    .total_len_i  (s_axis_tdata[23:8]),
    .last_byte_i  (s_axis_tlast),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // Decouple the byte-rate front from the bit-serial reducer.
  shbi_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Back: reduce modulo the bucket count and drive the master stream.
  shbi_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .bucket_count_i (bucket_count_q),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_data_i     (pop_data),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_data_o     (m_axis_tdata)
  );

endmodule

`default_nettype wire
